### rtl/core/knt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword and number tokenizer package
// Transaction types, token kinds, scan phases and character codes shared by
// the tokenizer RTL.
// ----------------------------------------------------------------------------
package knt_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int TOKEN_VALUE_W  = 32;
    localparam int KIND_W         = 4;
    localparam int PHASE_W        = 4;

    // Depth of the result queue; a power of two of at least two.
    localparam int OUT_FIFO_DEPTH = 4;

    // Token kinds.
    localparam logic [KIND_W-1:0] K_VAR     = 4'd0;
    localparam logic [KIND_W-1:0] K_NUM     = 4'd1;
    localparam logic [KIND_W-1:0] K_ASSIGN  = 4'd2;
    localparam logic [KIND_W-1:0] K_PLUS    = 4'd3;
    localparam logic [KIND_W-1:0] K_MINUS   = 4'd4;
    localparam logic [KIND_W-1:0] K_SEMI    = 4'd5;
    localparam logic [KIND_W-1:0] K_LOOP    = 4'd6;
    localparam logic [KIND_W-1:0] K_DO      = 4'd7;
    localparam logic [KIND_W-1:0] K_END     = 4'd8;
    localparam logic [KIND_W-1:0] K_EOF     = 4'd9;
    localparam logic [KIND_W-1:0] K_INVALID = 4'd10;

    // Scan phases.
    localparam logic [PHASE_W-1:0] PH_IDLE  = 4'd0;
    localparam logic [PHASE_W-1:0] PH_VAR   = 4'd1;
    localparam logic [PHASE_W-1:0] PH_NUM   = 4'd2;
    localparam logic [PHASE_W-1:0] PH_COLON = 4'd3;
    localparam logic [PHASE_W-1:0] PH_L     = 4'd4;
    localparam logic [PHASE_W-1:0] PH_LO    = 4'd5;
    localparam logic [PHASE_W-1:0] PH_LOO   = 4'd6;
    localparam logic [PHASE_W-1:0] PH_D     = 4'd7;
    localparam logic [PHASE_W-1:0] PH_E     = 4'd8;
    localparam logic [PHASE_W-1:0] PH_EN    = 4'd9;

    // Value reported with an invalid token caused by end of input.
    localparam logic [TOKEN_VALUE_W-1:0] END_CODE = 32'd256;

    // Character codes.
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0]        token_kind;
        logic [TOKEN_VALUE_W-1:0] token_value;
        logic                     last_of_run;
    } t_out_item;

endpackage

### rtl/core/keyword_number_tokenizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword and number tokenizer, top level
// Scans a character stream and emits variable, number, operator, keyword,
// end-of-input and invalid-character tokens.
// ----------------------------------------------------------------------------
// One character (or an end-of-input mark) is accepted per input transaction,
// and a new one can be taken in every cycle while the scan stage is not held
// back by the queue. Each character passes through an input register, then
// one pass of scan logic (a small phase transition and a times-ten-plus-digit
// update of the accumulator) writes its zero, one or two tokens into a
// four-entry result queue, from which the first token of a character is
// offered. The queue drains one token per cycle while the consumer is ready;
// the scan stage advances only while the queue has room for two tokens, so a
// stream in which every character closes a number or variable and also yields
// a token of its own can hold the input back, and any other stream runs at one
// character per cycle when the consumer keeps up. The last token produced by a
// character carries last_of_run. Number and variable values wrap modulo
// 2^VALUE_BITS and are reported in the low bits of token_value.
module keyword_number_tokenizer_top
    import knt_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int PTR_W   = $clog2(OUT_FIFO_DEPTH);
    localparam int COUNT_W = PTR_W + 1;

    // Input register.
    logic     r_in_valid;
    t_in_item r_in_data;

    // Scan state.
    logic [PHASE_W-1:0]    r_phase, n_phase;
    logic [VALUE_BITS-1:0] r_acc, n_acc;

    // Result queue.
    t_out_item          r_fifo [OUT_FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [COUNT_W-1:0] r_count, n_count;

    logic w_fire;
    logic w_pop;

    // The scan stage moves only when the queue can take two tokens.
    assign w_fire     = r_in_valid && (r_count <= COUNT_W'(OUT_FIFO_DEPTH - 2));
    assign o_in_ready = !r_in_valid || w_fire;
    assign w_pop      = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    // Character classification.
    logic [7:0] w_c;
    logic       w_eoi;
    logic       w_is_digit;
    logic       w_is_space;
    logic [3:0] w_digit;

    assign w_c        = r_in_data.char_code;
    assign w_eoi      = r_in_data.end_of_input;
    assign w_is_digit = !w_eoi && (w_c >= CH_ZERO) && (w_c <= CH_NINE);
    assign w_is_space = !w_eoi && ((w_c == CH_SPACE) || ((w_c >= CH_TAB) && (w_c <= CH_CR)));
    assign w_digit    = w_c[3:0];

    // Accumulator value as it appears in token_value.
    logic [TOKEN_VALUE_W-1:0] w_acc_ext;
    generate
        if (VALUE_BITS >= TOKEN_VALUE_W) begin : g_acc_trunc
            assign w_acc_ext = r_acc[TOKEN_VALUE_W-1:0];
        end else begin : g_acc_zext
            assign w_acc_ext = {{(TOKEN_VALUE_W - VALUE_BITS){1'b0}}, r_acc};
        end
    endgenerate

    // What the current symbol does when it starts a new token.
    logic                     s_emit;
    logic [KIND_W-1:0]        s_kind;
    logic [TOKEN_VALUE_W-1:0] s_value;
    logic [PHASE_W-1:0]       s_phase;
    logic                     s_load;
    logic [VALUE_BITS-1:0]    s_acc;

    always_comb begin
        s_emit  = 1'b0;
        s_kind  = K_INVALID;
        s_value = '0;
        s_phase = PH_IDLE;
        s_load  = 1'b0;
        s_acc   = '0;
        if (w_eoi) begin
            s_emit = 1'b1;
            s_kind = K_EOF;
        end else if (w_is_space) begin
            s_emit = 1'b0;
        end else if (w_is_digit) begin
            s_phase = PH_NUM;
            s_load  = 1'b1;
            s_acc   = VALUE_BITS'(w_digit);
        end else begin
            case (w_c)
                CH_X: begin
                    s_phase = PH_VAR;
                    s_load  = 1'b1;
                end
                CH_COLON: s_phase = PH_COLON;
                CH_L:     s_phase = PH_L;
                CH_D:     s_phase = PH_D;
                CH_E:     s_phase = PH_E;
                CH_PLUS: begin
                    s_emit = 1'b1;
                    s_kind = K_PLUS;
                end
                CH_MINUS: begin
                    s_emit = 1'b1;
                    s_kind = K_MINUS;
                end
                CH_SEMI: begin
                    s_emit = 1'b1;
                    s_kind = K_SEMI;
                end
                default: begin
                    s_emit  = 1'b1;
                    s_kind  = K_INVALID;
                    s_value = TOKEN_VALUE_W'(w_c);
                end
            endcase
        end
    end

    // Expected character and follow-up for keyword and ':=' phases.
    logic [7:0]         e_want;
    logic [PHASE_W-1:0] e_next;
    logic [KIND_W-1:0]  e_kind;
    logic               e_match;

    always_comb begin
        e_want = CH_EQ;
        e_next = PH_IDLE;
        e_kind = K_ASSIGN;
        case (r_phase)
            PH_COLON: begin
                e_want = CH_EQ;
                e_kind = K_ASSIGN;
            end
            PH_L: begin
                e_want = CH_O;
                e_next = PH_LO;
            end
            PH_LO: begin
                e_want = CH_O;
                e_next = PH_LOO;
            end
            PH_LOO: begin
                e_want = CH_P;
                e_kind = K_LOOP;
            end
            PH_D: begin
                e_want = CH_O;
                e_kind = K_DO;
            end
            PH_E: begin
                e_want = CH_N;
                e_next = PH_EN;
            end
            PH_EN: begin
                e_want = CH_D;
                e_kind = K_END;
            end
            default: begin
                e_want = CH_EQ;
            end
        endcase
    end

    assign e_match = !w_eoi && (w_c == e_want);

    // Scan step: up to two tokens per character.
    logic                     t0_valid, t1_valid;
    logic [KIND_W-1:0]        t0_kind, t1_kind;
    logic [TOKEN_VALUE_W-1:0] t0_value, t1_value;

    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        t0_valid = 1'b0;
        t0_kind  = K_INVALID;
        t0_value = '0;
        t1_valid = 1'b0;
        t1_kind  = s_kind;
        t1_value = s_value;
        case (r_phase)
            PH_VAR, PH_NUM: begin
                if (w_is_digit) begin
                    n_acc = (r_acc << 3) + (r_acc << 1) + VALUE_BITS'(w_digit);
                end else begin
                    // The closing character also starts the next token.
                    t0_valid = 1'b1;
                    t0_kind  = (r_phase == PH_VAR) ? K_VAR : K_NUM;
                    t0_value = w_acc_ext;
                    t1_valid = s_emit;
                    n_phase  = s_phase;
                    if (s_load) begin
                        n_acc = s_acc;
                    end
                end
            end
            PH_COLON, PH_L, PH_LO, PH_LOO, PH_D, PH_E, PH_EN: begin
                if (!e_match) begin
                    t0_valid = 1'b1;
                    t0_kind  = K_INVALID;
                    t0_value = w_eoi ? END_CODE : TOKEN_VALUE_W'(w_c);
                    n_phase  = PH_IDLE;
                end else if (e_next != PH_IDLE) begin
                    n_phase = e_next;
                end else begin
                    t0_valid = 1'b1;
                    t0_kind  = e_kind;
                    n_phase  = PH_IDLE;
                end
            end
            default: begin
                t0_valid = s_emit;
                t0_kind  = s_kind;
                t0_value = s_value;
                n_phase  = s_phase;
                if (s_load) begin
                    n_acc = s_acc;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_acc   <= '0;
        end else if (w_fire) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
        end
    end

    // Result queue. The second token of a character lands right after the first.
    logic [1:0] w_push_n;
    assign w_push_n = {1'b0, t0_valid} + {1'b0, t1_valid};

    always_comb begin
        n_count = r_count;
        if (w_fire) begin
            n_count = n_count + COUNT_W'(w_push_n);
        end
        if (w_pop) begin
            n_count = n_count - COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_fire) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(w_push_n);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && t0_valid) begin
            r_fifo[r_wr_ptr] <= '{token_kind: t0_kind, token_value: t0_value,
                                  last_of_run: !t1_valid};
        end
        if (w_fire && t1_valid) begin
            r_fifo[r_wr_ptr + PTR_W'(1)] <= '{token_kind: t1_kind, token_value: t1_value,
                                              last_of_run: 1'b1};
        end
    end

    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_fifo[r_rd_ptr];

`ifndef SYNTHESIS
    // The queue never holds more tokens than it has entries.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(OUT_FIFO_DEPTH))
        else $error("result queue overfilled");

    // The scan phase only takes defined codes.
    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PH_EN)
        else $error("scan phase holds an undefined code");

    // A second token is only ever produced behind a first one.
    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        t1_valid |-> t0_valid)
        else $error("second token without a first token");

    // A digit inside a number or variable produces no token.
    a_digit_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_is_digit && (r_phase == PH_VAR || r_phase == PH_NUM))
            |-> (w_push_n == 2'd0))
        else $error("digit inside a number produced a token");

    // The queue grows by at most two tokens per cycle.
    a_growth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (r_count <= $past(r_count) + COUNT_W'(2)))
        else $error("result queue grew by more than two tokens");
`endif

endmodule
